### rtl/core/radix2_fft_power_spectrum_macros.svh
// assertion macros for the fft power spectrum core
// no dependencies; included by fps_engine, which checks its own logic
`ifndef RADIX2_FFT_POWER_SPECTRUM_MACROS_SVH
`define RADIX2_FFT_POWER_SPECTRUM_MACROS_SVH

// same-cycle implication
`define FPS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fft power spectrum check failed");

// next-cycle implication
`define FPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fft power spectrum check failed");

`endif

### rtl/core/fps_pkg.sv
// types, widths and the twiddle generator for the fft power spectrum core
// no dependencies
package fps_pkg;

   localparam int SAMPLE_W = 16;
   localparam int WORK_W   = 25;
   localparam int TW_W     = 17;
   localparam int POWER_W  = 48;
   localparam int ENERGY_W = 64;
   localparam int SHIFT_W  = 6;
   localparam int BIN_W    = 8;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd32;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   localparam logic [63:0] TAYLOR_SIN_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
   localparam logic [63:0] TAYLOR_COS_DIV [12] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   typedef struct packed {
      logic signed [TW_W-1:0] c;
      logic signed [TW_W-1:0] s;
   } tw_pair_type;

   // q30 to q15, round half up, clamp to [0, 32767]
   function automatic logic signed [TW_W-1:0] to_q15(input logic signed [63:0] q30);
      logic signed [63:0] v;
      v = (q30 + 64'sd16384) >>> 15;
      if (q30 < 0) begin
         return '0;
      end else if (v > 64'sd32767) begin
         return TW_W'(32767);
      end else begin
         return TW_W'(v);
      end
   endfunction

   // cos and sin of 2*pi*k/2^stages from a q30 taylor series, evaluated at elaboration
   function automatic tw_pair_type twiddle(input int unsigned k, input int unsigned Stages);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic signed [63:0] ss;
      logic signed [63:0] sc;
      logic signed [TW_W-1:0] cq;
      logic signed [TW_W-1:0] sq;
      int unsigned j;
      int unsigned quarter;
      tw_pair_type r;
      quarter = 1 << (Stages - 2);
      j = (k <= quarter) ? k : k - quarter;
      x = (64'(j) * TWO_PI_Q30 + (64'd1 << (Stages - 1))) >> Stages;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = $signed(x);
      sc = $signed(64'd1 << 30);
      for (int n = 1; n <= 12; n++) begin
         ts = ((ts * x2) >> 30) / TAYLOR_SIN_DIV[n-1];
         tc = ((tc * x2) >> 30) / TAYLOR_COS_DIV[n-1];
         if (n % 2 == 1) begin
            ss = ss - $signed(ts);
            sc = sc - $signed(tc);
         end else begin
            ss = ss + $signed(ts);
            sc = sc + $signed(tc);
         end
      end
      cq = to_q15(sc);
      sq = to_q15(ss);
      if (k <= quarter) begin
         r.c = cq;
         r.s = sq;
      end else begin
         r.c = -sq;
         r.s = cq;
      end
      return r;
   endfunction

endpackage

### rtl/core/radix2_fft_power_spectrum.sv
// channel  | ports                         | payload
// req      | req_valid / req_ready         | req_sample
// rsp      | rsp_valid / rsp_ready         | rsp_bin_index, rsp_power, rsp_energy, rsp_last_bin
// csr      | csr_valid / csr_ready         | csr_energy_shift
//
// each sample passes the idle and emit states while bins stream out; the last sample of a frame
// starts the transform, which holds off new samples until the load, the butterfly passes on the
// single shared butterfly unit and the serial power/energy pass are done.
// reset is synchronous; no bins are returned until a first frame is done.
// a stalled rsp channel holds the engine, and the two-entry queue then backs up req.
// top level of the fft power spectrum core; depends on fps_pkg, fps_front, fps_queue
// and fps_engine
module radix2_fft_power_spectrum #(
   parameter int POINTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [fps_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fps_pkg::BIN_W-1:0]            rsp_bin_index,
   output logic [fps_pkg::POWER_W-1:0]          rsp_power,
   output logic [fps_pkg::ENERGY_W-1:0]         rsp_energy,
   output logic                                 rsp_last_bin,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fps_pkg::SHIFT_W-1:0]          csr_energy_shift
);
   import fps_pkg::*;

   localparam int AW = $clog2(POINTS);
   localparam int QW = 1 + AW + SAMPLE_W;

   logic [SHIFT_W-1:0] shift_ff, shift_in;

   logic                        push_valid, push_ready, push_last;
   logic signed [SAMPLE_W-1:0]  push_sample;
   logic [AW-1:0]               push_pos;
   logic                        pop_valid, pop_ready;
   logic [QW-1:0]               pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      shift_in = (csr_valid) ? csr_energy_shift : shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else begin
         shift_ff <= shift_in;
      end
   end

   fps_front #(.POINTS(POINTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_sample (push_sample),
      .push_pos    (push_pos),
      .push_last   (push_last)
   );

   fps_queue #(.W(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_last, push_pos, push_sample}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fps_engine #(.POINTS(POINTS)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .energy_shift  (shift_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_sample    (signed'(pop_data[SAMPLE_W-1:0])),
      .pop_pos       (pop_data[SAMPLE_W +: AW]),
      .pop_last      (pop_data[QW-1]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_power     (rsp_power),
      .rsp_energy    (rsp_energy),
      .rsp_last_bin  (rsp_last_bin)
   );

endmodule

### rtl/core/fps_queue.sv
// two-entry word queue between the sample front end and the fft engine
// no package dependencies
module fps_queue #(
   parameter int W = 25
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  logic [W-1:0] push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output logic [W-1:0] pop_data
);

   logic [W-1:0] slot_ff [2];
   logic         wr_ff, wr_in;
   logic         rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push_fire;
   logic         pop_fire;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push_fire ? ~wr_ff : wr_ff;
      rd_in  = pop_fire ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push_fire) - 2'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/fps_front.sv
// sample front end: tracks the position in the frame and tags the last sample
// depends on fps_pkg
module fps_front #(
   parameter int POINTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [fps_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic signed [fps_pkg::SAMPLE_W-1:0]  push_sample,
   output logic [$clog2(POINTS)-1:0]            push_pos,
   output logic                                 push_last
);
   import fps_pkg::*;

   localparam int AW = $clog2(POINTS);

   logic [AW-1:0] pos_ff, pos_in;

   assign req_ready   = push_ready;
   assign push_valid  = req_valid;
   assign push_sample = req_sample;
   assign push_pos    = pos_ff;
   assign push_last   = (pos_ff == AW'(POINTS - 1));

   // wraps naturally at the frame end
   always_comb begin
      pos_in = (req_valid && push_ready) ? pos_ff + AW'(1) : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/core/fps_engine.sv
// fft engine: frame stores, bin-serving, butterfly sequencer, power and energy
// depends on fps_pkg and the assertion macro header
`include "radix2_fft_power_spectrum_macros.svh"

module fps_engine #(
   parameter int POINTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [fps_pkg::SHIFT_W-1:0]          energy_shift,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  logic signed [fps_pkg::SAMPLE_W-1:0]  pop_sample,
   input  logic [$clog2(POINTS)-1:0]            pop_pos,
   input  logic                                 pop_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fps_pkg::BIN_W-1:0]            rsp_bin_index,
   output logic [fps_pkg::POWER_W-1:0]          rsp_power,
   output logic [fps_pkg::ENERGY_W-1:0]         rsp_energy,
   output logic                                 rsp_last_bin
);
   import fps_pkg::*;

   localparam int AW   = $clog2(POINTS);
   localparam int JW   = AW - 1;
   localparam int HALF = POINTS / 2;
   localparam int SW   = $clog2(AW);

   typedef enum logic [3:0] {
      S_IDLE, S_EMIT, S_LOAD,
      S_BF_RD, S_BF_MUL, S_BF_ADD, S_BF_WU, S_BF_WL,
      S_PW_RD, S_PW_SQ, S_PW_SUM, S_PW_M0, S_PW_M1, S_PW_M2, S_PW_SH, S_PW_ACC
   } state_type;

   // memories
   logic signed [SAMPLE_W-1:0] in_mem   [POINTS];
   logic signed [WORK_W-1:0]   work_re  [POINTS];
   logic signed [WORK_W-1:0]   work_im  [POINTS];
   logic [POWER_W-1:0]         pw_mem   [POINTS];

   tw_pair_type tw_rom [HALF];

   for (genvar k = 0; k < HALF; k++) begin : g_tw
      localparam tw_pair_type TW = twiddle(k, AW);
      assign tw_rom[k] = TW;
   end

   function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
      logic [AW-1:0] r;
      for (int b = 0; b < AW; b++) begin
         r[b] = v[AW-1-b];
      end
      return r;
   endfunction

   function automatic logic signed [WORK_W-1:0] sat25(input logic signed [WORK_W+3:0] v);
      if (v > (WORK_W+4)'(25'sh0FFFFFF)) begin
         return {1'b0, {(WORK_W-1){1'b1}}};
      end else if (v < (WORK_W+4)'(25'sh1000000)) begin
         return {1'b1, {(WORK_W-1){1'b0}}};
      end else begin
         return WORK_W'(v);
      end
   endfunction

   // state and registered outputs
   state_type               state_ff, state_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [JW-1:0]           j_ff, j_in;
   logic [SW-1:0]           st_ff, st_in;
   logic                    ld_pend_ff, ld_pend_in;
   logic [AW-1:0]           ld_addr_ff, ld_addr_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic                    last_ff, last_in;
   logic [SHIFT_W-1:0]      shift_ff, shift_in;
   logic                    spectrum_ready_ff, spectrum_ready_in;
   logic [ENERGY_W-1:0]     frame_energy_ff, frame_energy_in;
   logic [ENERGY_W-1:0]     acc_ff, acc_in;
   logic signed [41:0]      cbr_ff, cbr_in, sbi_ff, sbi_in, cbi_ff, cbi_in, sbr_ff, sbr_in;
   logic signed [WORK_W-1:0] ar_ff, ar_in, ai_ff, ai_in;
   logic signed [WORK_W-1:0] ur_ff, ur_in, ui_ff, ui_in, lr_ff, lr_in, li_ff, li_in;
   logic [49:0]             rr_ff, rr_in, ii_ff, ii_in;
   logic [POWER_W-1:0]      pw_ff, pw_in;
   logic [95:0]             sq_ff, sq_in;
   logic [ENERGY_W-1:0]     sqs_ff, sqs_in;
   logic                    out_valid_ff, out_valid_in;
   logic [BIN_W-1:0]        out_bin_ff, out_bin_in;
   logic [POWER_W-1:0]      out_power_ff, out_power_in;
   logic [ENERGY_W-1:0]     out_energy_ff, out_energy_in;
   logic                    out_last_ff, out_last_in;

   // memory read registers
   logic signed [SAMPLE_W-1:0] in_rd_ff;
   logic signed [WORK_W-1:0]   ra_re_ff, ra_im_ff, rb_re_ff, rb_im_ff;
   logic [POWER_W-1:0]         pw_rd_ff;

   // combinational helpers
   logic                       pop_fire;
   logic [AW-1:0]              lowmask, j_ext, u_addr, l_addr;
   logic [JW-1:0]              tw_k;
   tw_pair_type                tw;
   logic [AW-1:0]              rd_a_addr, rd_b_addr;
   logic                       wk_we;
   logic [AW-1:0]              wk_addr;
   logic signed [WORK_W-1:0]   wk_re, wk_im;
   logic                       pw_we;
   logic signed [42:0]         sum_r, sum_i;
   logic signed [27:0]         tr, ti;
   logic [WORK_W-1:0]          mag_re, mag_im;
   logic [49:0]                psum;
   logic [95:0]                shifted;
   logic [ENERGY_W:0]          esum;
   logic [ENERGY_W-1:0]        esat;
   logic                       out_free;

   assign pop_ready = (state_ff == S_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_bin_index = out_bin_ff;
   assign rsp_power     = out_power_ff;
   assign rsp_energy    = out_energy_ff;
   assign rsp_last_bin  = out_last_ff;

   // butterfly addressing: insert a zero at bit st of j
   always_comb begin
      lowmask = (AW'(1) << st_ff) - AW'(1);
      j_ext   = AW'(j_ff);
      u_addr  = ((j_ext & ~lowmask) << 1) | (j_ext & lowmask);
      l_addr  = u_addr | (AW'(1) << st_ff);
      tw_k    = JW'((j_ext & lowmask) << (SW'(AW - 1) - st_ff));
      tw      = tw_rom[tw_k];
   end

   always_comb begin
      sum_r   = 43'(cbr_ff) + 43'(sbi_ff) + 43'sd16384;
      sum_i   = 43'(cbi_ff) - 43'(sbr_ff) + 43'sd16384;
      tr      = 28'(sum_r >>> 15);
      ti      = 28'(sum_i >>> 15);
      mag_re  = ra_re_ff[WORK_W-1] ? WORK_W'(-ra_re_ff) : WORK_W'(ra_re_ff);
      mag_im  = ra_im_ff[WORK_W-1] ? WORK_W'(-ra_im_ff) : WORK_W'(ra_im_ff);
      psum    = rr_ff + ii_ff;
      shifted = sq_ff >> shift_ff;
      esum    = (ENERGY_W+1)'(acc_ff) + (ENERGY_W+1)'(sqs_ff);
      esat    = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
   end

   // work memory ports
   always_comb begin
      rd_a_addr = idx_ff;
      rd_b_addr = l_addr;
      if (state_ff == S_BF_RD) begin
         rd_a_addr = u_addr;
      end
      wk_we   = 1'b0;
      wk_addr = u_addr;
      wk_re   = ur_ff;
      wk_im   = ui_ff;
      if (ld_pend_ff) begin
         wk_we   = 1'b1;
         wk_addr = ld_addr_ff;
         wk_re   = WORK_W'(in_rd_ff);
         wk_im   = '0;
      end else if (state_ff == S_BF_WU) begin
         wk_we = 1'b1;
      end else if (state_ff == S_BF_WL) begin
         wk_we   = 1'b1;
         wk_addr = l_addr;
         wk_re   = lr_ff;
         wk_im   = li_ff;
      end
      pw_we = (state_ff == S_PW_SUM);
   end

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      j_in              = j_ff;
      st_in             = st_ff;
      ld_pend_in        = 1'b0;
      ld_addr_in        = idx_ff;
      pos_in            = pos_ff;
      last_in           = last_ff;
      shift_in          = shift_ff;
      spectrum_ready_in = spectrum_ready_ff;
      frame_energy_in   = frame_energy_ff;
      acc_in            = acc_ff;
      cbr_in            = cbr_ff;
      sbi_in            = sbi_ff;
      cbi_in            = cbi_ff;
      sbr_in            = sbr_ff;
      ar_in             = ar_ff;
      ai_in             = ai_ff;
      ur_in             = ur_ff;
      ui_in             = ui_ff;
      lr_in             = lr_ff;
      li_in             = li_ff;
      rr_in             = rr_ff;
      ii_in             = ii_ff;
      pw_in             = pw_ff;
      sq_in             = sq_ff;
      sqs_in            = sqs_ff;
      out_valid_in      = out_valid_ff && !rsp_ready;
      out_bin_in        = out_bin_ff;
      out_power_in      = out_power_ff;
      out_energy_in     = out_energy_ff;
      out_last_in       = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop_fire) begin
               pos_in  = pop_pos;
               last_in = pop_last;
               // freeze the shift for the frame about to run
               shift_in = energy_shift;
               idx_in   = '0;
               if (spectrum_ready_ff) begin
                  state_in = S_EMIT;
               end else if (pop_last) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_bin_in    = BIN_W'(pos_ff);
               out_power_in  = pw_rd_ff;
               out_energy_in = last_ff ? frame_energy_ff : '0;
               out_last_in   = last_ff;
               state_in      = last_ff ? S_LOAD : S_IDLE;
            end
         end
         S_LOAD: begin
            ld_pend_in = 1'b1;
            ld_addr_in = idx_ff;
            idx_in     = idx_ff + AW'(1);
            if (idx_ff == AW'(POINTS - 1)) begin
               j_in     = '0;
               st_in    = '0;
               state_in = S_BF_RD;
            end
         end
         S_BF_RD: begin
            state_in = S_BF_MUL;
         end
         S_BF_MUL: begin
            ar_in    = ra_re_ff;
            ai_in    = ra_im_ff;
            cbr_in   = tw.c * rb_re_ff;
            sbi_in   = tw.s * rb_im_ff;
            cbi_in   = tw.c * rb_im_ff;
            sbr_in   = tw.s * rb_re_ff;
            state_in = S_BF_ADD;
         end
         S_BF_ADD: begin
            ur_in    = sat25((WORK_W+4)'(ar_ff) + (WORK_W+4)'(tr));
            ui_in    = sat25((WORK_W+4)'(ai_ff) + (WORK_W+4)'(ti));
            lr_in    = sat25((WORK_W+4)'(ar_ff) - (WORK_W+4)'(tr));
            li_in    = sat25((WORK_W+4)'(ai_ff) - (WORK_W+4)'(ti));
            state_in = S_BF_WU;
         end
         S_BF_WU: begin
            state_in = S_BF_WL;
         end
         S_BF_WL: begin
            j_in     = j_ff + JW'(1);
            state_in = S_BF_RD;
            if (j_ff == JW'(HALF - 1)) begin
               st_in = st_ff + SW'(1);
               if (st_ff == SW'(AW - 1)) begin
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = S_PW_RD;
               end
            end
         end
         S_PW_RD: begin
            state_in = S_PW_SQ;
         end
         S_PW_SQ: begin
            rr_in    = mag_re * mag_re;
            ii_in    = mag_im * mag_im;
            state_in = S_PW_SUM;
         end
         S_PW_SUM: begin
            // written to the power store this cycle
            pw_in    = (psum[49:POWER_W] != '0) ? '1 : psum[POWER_W-1:0];
            state_in = S_PW_M0;
         end
         S_PW_M0: begin
            sq_in    = 96'(pw_ff[31:0] * pw_ff[31:0]);
            state_in = S_PW_M1;
         end
         S_PW_M1: begin
            sq_in    = sq_ff + (96'(pw_ff[47:32] * pw_ff[31:0]) << 33);
            state_in = S_PW_M2;
         end
         S_PW_M2: begin
            sq_in    = sq_ff + (96'(pw_ff[47:32] * pw_ff[47:32]) << 64);
            state_in = S_PW_SH;
         end
         S_PW_SH: begin
            sqs_in   = (shifted[95:64] != '0) ? '1 : shifted[63:0];
            state_in = S_PW_ACC;
         end
         S_PW_ACC: begin
            acc_in   = esat;
            idx_in   = idx_ff + AW'(1);
            state_in = S_PW_RD;
            if (idx_ff == AW'(POINTS - 1)) begin
               frame_energy_in   = esat;
               spectrum_ready_in = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         ld_pend_ff        <= 1'b0;
         spectrum_ready_ff <= 1'b0;
         frame_energy_ff   <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         ld_pend_ff        <= ld_pend_in;
         spectrum_ready_ff <= spectrum_ready_in;
         frame_energy_ff   <= frame_energy_in;
         out_valid_ff      <= out_valid_in;
      end
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      st_ff         <= st_in;
      ld_addr_ff    <= ld_addr_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      shift_ff      <= shift_in;
      acc_ff        <= acc_in;
      cbr_ff        <= cbr_in;
      sbi_ff        <= sbi_in;
      cbi_ff        <= cbi_in;
      sbr_ff        <= sbr_in;
      ar_ff         <= ar_in;
      ai_ff         <= ai_in;
      ur_ff         <= ur_in;
      ui_ff         <= ui_in;
      lr_ff         <= lr_in;
      li_ff         <= li_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      pw_ff         <= pw_in;
      sq_ff         <= sq_in;
      sqs_ff        <= sqs_in;
      out_bin_ff    <= out_bin_in;
      out_power_ff  <= out_power_in;
      out_energy_ff <= out_energy_in;
      out_last_ff   <= out_last_in;
   end

   // sample store
   always_ff @(posedge clock) begin
      if (pop_fire) begin
         in_mem[pop_pos] <= pop_sample;
      end
      in_rd_ff <= in_mem[bit_rev(idx_ff)];
   end

   // work stores, two read ports and one write port
   always_ff @(posedge clock) begin
      if (wk_we) begin
         work_re[wk_addr] <= wk_re;
         work_im[wk_addr] <= wk_im;
      end
      ra_re_ff <= work_re[rd_a_addr];
      ra_im_ff <= work_im[rd_a_addr];
      rb_re_ff <= work_re[rd_b_addr];
      rb_im_ff <= work_im[rd_b_addr];
   end

   // power store
   always_ff @(posedge clock) begin
      if (pw_we) begin
         pw_mem[idx_ff] <= pw_in;
      end
      if (pop_fire) begin
         pw_rd_ff <= pw_mem[pop_pos];
      end
   end

   `FPS_ASSERT_IMPLIES(a_last_bin_index, clock, reset, out_valid_ff && out_last_ff, out_bin_ff == BIN_W'(POINTS - 1))
   `FPS_ASSERT_IMPLIES(a_energy_only_last, clock, reset, out_valid_ff && !out_last_ff, out_energy_ff == '0)
   `FPS_ASSERT_IMPLIES(a_no_pop_busy, clock, reset, state_ff != S_IDLE, !pop_ready)
   `FPS_ASSERT_NEXT(a_ready_after_frame, clock, reset, state_ff == S_PW_ACC && idx_ff == AW'(POINTS - 1), spectrum_ready_ff)

endmodule

### tb/sv/radix2_fft_power_spectrum_tb.sv
// self-checking bench for the 256-point fft power spectrum core: streams sample frames,
// predicts each bin's power and the frame energy, and checks every returned bin
// depends on fps_pkg and radix2_fft_power_spectrum
module radix2_fft_power_spectrum_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fps_pkg::*;

   localparam int NPTS = 256;
   localparam int NLOG = 8;
   localparam int SETTLE = 8000;
   localparam int CYCLE_LIMIT = 1000000;

   typedef enum int {
      FRAME_CONST, FRAME_ALT, FRAME_IMPULSE, FRAME_RANDOM, FRAME_QUIET
   } frame_kind_type;

   typedef struct {
      logic [BIN_W-1:0]    bin;
      logic [POWER_W-1:0]  power;
      logic [ENERGY_W-1:0] energy;
      logic                last;
   } bin_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BIN_W-1:0] rsp_bin_index;
   logic [POWER_W-1:0] rsp_power;
   logic [ENERGY_W-1:0] rsp_energy;
   logic rsp_last_bin;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SHIFT_W-1:0] csr_energy_shift = '0;

   radix2_fft_power_spectrum dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_bin_index(rsp_bin_index),
      .rsp_power(rsp_power), .rsp_energy(rsp_energy), .rsp_last_bin(rsp_last_bin),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_energy_shift(csr_energy_shift)
   );

   // spectrum tracking state
   longint rom_c [NPTS/2];
   longint rom_s [NPTS/2];
   longint frame_buf [NPTS];
   logic [POWER_W-1:0] power_tbl [NPTS];
   logic [ENERGY_W-1:0] energy_sum;
   int sample_pos;
   bit spectrum_valid;
   logic [SHIFT_W-1:0] shift_q = SHIFT_RESET;

   logic signed [SAMPLE_W-1:0] samples_pending [$];
   bin_word_type bins_due [$];
   int errors = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit steady = 1'b0;
   longint cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint taylor_q15(longint v);
      longint r;
      if (v < 0) return 0;
      r = (v + 16384) >>> 15;
      return (r > 32767) ? 32767 : r;
   endfunction

   // cos/sin of 2*pi*j/NPTS in q15 for j in the first quarter wave
   function automatic void quarter_point(int j, output longint c, output longint s);
      longint unsigned x, x2, ts, tc;
      longint ss, sc;
      x = (longint'(j) * 64'd6746518852 + NPTS / 2) / NPTS;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      sc = longint'(64'd1 << 30);
      for (int n = 1; n <= 12; n++) begin
         ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
         tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            ss -= longint'(ts);
            sc -= longint'(tc);
         end else begin
            ss += longint'(ts);
            sc += longint'(tc);
         end
      end
      c = taylor_q15(sc);
      s = taylor_q15(ss);
   endfunction

   function automatic longint clip25(longint v);
      if (v > 16777215) return 16777215;
      if (v < -16777216) return -16777216;
      return v;
   endfunction

   // full transform of the buffered frame, power per bin and the shifted energy
   function automatic void transform_frame();
      longint wr [NPTS];
      longint wi [NPTS];
      longint c, sn, tr, ti, ar, ai;
      int rev, half, tstep, u, l, k;
      logic [127:0] pw, sq;
      logic [64:0] acc;
      for (int i = 0; i < NPTS; i++) begin
         rev = 0;
         for (int b = 0; b < NLOG; b++) rev = (rev << 1) | ((i >> b) & 1);
         wr[i] = frame_buf[rev];
         wi[i] = 0;
      end
      for (int st = 1; st <= NLOG; st++) begin
         half = 1 << (st - 1);
         tstep = NPTS >> st;
         for (int base = 0; base < NPTS; base += 2 * half) begin
            for (int p = 0; p < half; p++) begin
               u = base + p;
               l = u + half;
               k = (p * tstep) & (NPTS / 2 - 1);
               c = rom_c[k];
               sn = rom_s[k];
               tr = (c * wr[l] + sn * wi[l] + 16384) >>> 15;
               ti = (c * wi[l] - sn * wr[l] + 16384) >>> 15;
               ar = wr[u];
               ai = wi[u];
               wr[u] = clip25(ar + tr);
               wi[u] = clip25(ai + ti);
               wr[l] = clip25(ar - tr);
               wi[l] = clip25(ai - ti);
            end
         end
      end
      acc = '0;
      for (int i = 0; i < NPTS; i++) begin
         pw = 128'(wr[i] * wr[i]) + 128'(wi[i] * wi[i]);
         if (pw > 128'hFFFF_FFFF_FFFF) pw = 128'hFFFF_FFFF_FFFF;
         power_tbl[i] = pw[POWER_W-1:0];
         sq = (pw * pw) >> shift_q;
         if (sq[127:64] != 0) sq = 128'hFFFF_FFFF_FFFF_FFFF;
         acc = acc + sq[64:0];
         if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      energy_sum = acc[63:0];
      spectrum_valid = 1'b1;
   endfunction

   // one accepted sample: queue the bin it releases, then store it
   function automatic void take_sample(logic signed [SAMPLE_W-1:0] smp);
      bin_word_type w;
      bit last;
      last = (sample_pos == NPTS - 1);
      if (spectrum_valid) begin
         w.bin = BIN_W'(sample_pos);
         w.power = power_tbl[sample_pos];
         w.energy = last ? energy_sum : '0;
         w.last = last;
         bins_due.push_back(w);
      end
      frame_buf[sample_pos] = longint'(smp);
      if (last) begin
         transform_frame();
         sample_pos = 0;
      end else begin
         sample_pos++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) take_sample(req_sample);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (samples_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_sample <= samples_pending.pop_front();
               gap_left <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bin_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bins_due.size() == 0) begin
               report_mismatch("unexpected word bin", 64'(rsp_bin_index), 64'hx);
            end else begin
               w = bins_due.pop_front();
               if (rsp_bin_index !== w.bin)
                  report_mismatch("bin_index", 64'(rsp_bin_index), 64'(w.bin));
               if (rsp_power !== w.power)
                  report_mismatch("power", 64'(rsp_power), 64'(w.power));
               if (rsp_energy !== w.energy)
                  report_mismatch("energy", rsp_energy, w.energy);
               if (rsp_last_bin !== w.last)
                  report_mismatch("last_bin", 64'(rsp_last_bin), 64'(w.last));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall_left <= pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("radix2_fft_power_spectrum regression: fail");
         $finish;
      end
   end

   task automatic queue_frame(input frame_kind_type kind);
      logic signed [SAMPLE_W-1:0] lvl;
      lvl = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      for (int i = 0; i < NPTS; i++) begin
         case (kind)
            FRAME_CONST: samples_pending.push_back(lvl);
            FRAME_ALT: samples_pending.push_back(i % 2 ? 16'sh8000 : 16'sh7FFF);
            FRAME_IMPULSE: samples_pending.push_back(i == 0 ? lvl : 16'sh0000);
            FRAME_RANDOM: samples_pending.push_back(SAMPLE_W'($urandom));
            default: samples_pending.push_back(SAMPLE_W'($urandom_range(0, 255)) - 16'sd128);
         endcase
      end
   endtask

   task automatic drain_and_settle(input int extra);
      do @(posedge clock);
      while (samples_pending.size() != 0 || req_valid || bins_due.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_shift(input logic [SHIFT_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_energy_shift <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      shift_q = v;
   endtask

   initial begin
      longint c, s;
      for (int k = 0; k < NPTS / 2; k++) begin
         if (k <= NPTS / 4) begin
            quarter_point(k, c, s);
            rom_c[k] = c;
            rom_s[k] = s;
         end else begin
            quarter_point(k - NPTS / 4, c, s);
            rom_c[k] = -s;
            rom_s[k] = c;
         end
      end
      sample_pos = 0;
      spectrum_valid = 1'b0;
      energy_sum = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset shift value first, then full-scale and random frames
      queue_frame(FRAME_CONST);
      drain_and_settle(SETTLE);
      write_shift(6'd0);
      queue_frame(FRAME_ALT);
      drain_and_settle(SETTLE);
      steady = 1'b1;
      write_shift(SHIFT_W'($urandom_range(0, 63)));
      queue_frame(FRAME_RANDOM);
      drain_and_settle(SETTLE);
      steady = 1'b0;
      write_shift(6'd63);
      // release the last spectrum
      queue_frame(FRAME_IMPULSE);
      drain_and_settle(100);

      if (errors == 0) begin
         $display("radix2_fft_power_spectrum regression: pass");
      end else begin
         $display("radix2_fft_power_spectrum regression: fail");
      end
      $finish;
   end

endmodule
